// ===== hw/rtl/merge_sorter_core_assert.svh =====
// Assertion macros for the merge sorter core.
`ifndef MERGE_SORTER_CORE_ASSERT_SVH
`define MERGE_SORTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MSORT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("msort: assertion failed");

// Next-cycle implication, disabled during reset.
`define MSORT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("msort: assertion failed");

`endif

// ===== hw/rtl/msort_pkg.sv =====
// Shared constants and types of the merge sorter.
package msort_pkg;

	localparam int MaxItemsDef   = 64;
	localparam int ValueWidthDef = 32;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/msort_in_if.sv =====
// Input channel: one element per request.
interface msort_in_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          is_final;

	modport source (output valid, output value, output is_final, input ready);
	modport sink   (input valid, input value, input is_final, output ready);
endinterface

// ===== hw/rtl/msort_out_if.sv =====
// Output channel: one sorted element per request.
interface msort_out_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] sorted_value;
	logic                          end_of_run;
	logic                          dropped;

	modport source (output valid, output sorted_value, output end_of_run, output dropped,
		input ready);
	modport sink   (input valid, input sorted_value, input end_of_run, input dropped,
		output ready);
endinterface

// ===== hw/rtl/msort_cell.sv =====
// One sorting cell: holds one element, inserts in order or shifts toward the head.
module msort_cell
	import msort_pkg::*;
#(
	parameter int VALUE_WIDTH = ValueWidthDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cell_ctl_t                     ctl,
	input  logic signed [VALUE_WIDTH-1:0] x,
	input  logic signed [VALUE_WIDTH-1:0] left_val,
	input  logic                          left_vld,
	input  logic                          left_lt,
	input  logic signed [VALUE_WIDTH-1:0] right_val,
	input  logic                          right_vld,
	output logic signed [VALUE_WIDTH-1:0] val_q,
	output logic                          vld_q,
	output logic                          lt
);

	// new element belongs at or before this cell
	assign lt = !vld_q || (x < val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= right_vld;
		end else if (ctl.insert && lt) begin
			vld_q <= left_lt ? left_vld : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= right_val;
		end else if (ctl.insert && lt) begin
			val_q <= left_lt ? left_val : x;
		end
	end

endmodule

// ===== hw/rtl/merge_sorter_core.sv =====
// Merge sorter core: sorts a run of signed elements in a chain of insertion cells.
//
// din carries one element per request; is_final marks the last element of a run.
// Each element is inserted into a row of MAX_ITEMS cells as it is accepted, so the
// chain always holds the run in ascending order. The element count is the
// number of valid cells; an element arriving with all cells full is dropped.
// After the final request is taken, din.ready stays low and the run drains
// from the head cell on dout, one result per cycle while dout.ready is high.
// The first result is valid the cycle after the final request. Loading and
// draining of a run do not overlap: the chain does either an insert or a
// shift, never both, and din.ready is low while the run drains.
// end_of_run marks the last result; dropped is set on it if any element of the
// run was lost. A stalled receiver simply freezes the chain with the current
// result held on dout. After end_of_run is taken din.ready rises again.
// Reset clears all cell valid bits and the drain and overflow flags; no
// clearing pass is needed.
module merge_sorter_core
	import msort_pkg::*;
#(
	parameter int MAX_ITEMS   = MaxItemsDef,
	parameter int VALUE_WIDTH = ValueWidthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	msort_in_if.sink    din,
	msort_out_if.source dout
);

`include "merge_sorter_core_assert.svh"

	logic signed [VALUE_WIDTH-1:0] cell_val [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]          cell_vld;
	logic [MAX_ITEMS-1:0]          cell_lt;
	logic                          draining_q;
	logic                          ovf_q;
	logic                          in_fire;
	logic                          out_fire;
	logic                          full;
	logic                          run_end;
	cell_ctl_t                     ctl;

	assign full     = cell_vld[MAX_ITEMS-1];
	assign in_fire  = din.valid && din.ready;
	assign out_fire = dout.valid && dout.ready;
	assign run_end  = out_fire && dout.end_of_run;

	assign ctl.insert = in_fire && !full;
	assign ctl.shift  = out_fire;

	assign din.ready         = !draining_q;
	assign dout.valid        = draining_q && cell_vld[0];
	assign dout.sorted_value = cell_val[0];
	assign dout.end_of_run   = !cell_vld[1];
	assign dout.dropped      = !cell_vld[1] && ovf_q;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic signed [VALUE_WIDTH-1:0] l_val;
		logic                          l_vld;
		logic                          l_lt;
		logic signed [VALUE_WIDTH-1:0] r_val;
		logic                          r_vld;

		if (i == 0) begin : g_head
			assign l_val = '0;
			assign l_vld = 1'b0;
			assign l_lt  = 1'b0;
		end else begin : g_body
			assign l_val = cell_val[i-1];
			assign l_vld = cell_vld[i-1];
			assign l_lt  = cell_lt[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign r_val = '0;
			assign r_vld = 1'b0;
		end else begin : g_inner
			assign r_val = cell_val[i+1];
			assign r_vld = cell_vld[i+1];
		end

		msort_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.x        (din.value),
			.left_val (l_val),
			.left_vld (l_vld),
			.left_lt  (l_lt),
			.right_val(r_val),
			.right_vld(r_vld),
			.val_q    (cell_val[i]),
			.vld_q    (cell_vld[i]),
			.lt       (cell_lt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			if (in_fire && din.is_final) begin
				draining_q <= 1'b1;
			end else if (run_end) begin
				draining_q <= 1'b0;
			end
			if (in_fire && full) begin
				ovf_q <= 1'b1;
			end else if (run_end) begin
				ovf_q <= 1'b0;
			end
		end
	end

	`MSORT_ASSERT_NOW(a_no_load_while_drain, clk, arst_n, dout.valid, !din.ready)
	`MSORT_ASSERT_NOW(a_dropped_on_last, clk, arst_n, dout.valid && dout.dropped,
		dout.end_of_run)
	`MSORT_ASSERT_NEXT(a_final_starts_drain, clk, arst_n, in_fire && din.is_final, dout.valid)
	`MSORT_ASSERT_NOW(a_cells_packed, clk, arst_n, 1'b1,
		(cell_vld & (cell_vld + {{(MAX_ITEMS-1){1'b0}}, 1'b1})) == '0)
	`MSORT_ASSERT_NEXT(a_run_end_frees_input, clk, arst_n, run_end, din.ready)

endmodule

// ===== sim/merge_sorter_core_test.sv =====
// Self-checking testbench of merge_sorter_core: directed and random runs vs. a sort predictor.
`timescale 1ns / 100ps

module merge_sorter_core_test
	import msort_pkg::*;
();

	localparam logic signed [ValueWidthDef-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [ValueWidthDef-1:0] VALUE_MAX = 32'sh7fff_ffff;
	localparam int RANDOM_ELEMENTS = 190;
	localparam int SETTLE_CYCLES   = 2 * MaxItemsDef + 8;
	localparam int HOLDOFF_CYCLES  = 400;
	localparam int CYCLE_LIMIT     = 300000;

	typedef struct packed {
		logic signed [ValueWidthDef-1:0] value;
		logic                            end_of_run;
		logic                            dropped;
	} sorted_result_t;

	typedef struct packed {
		logic signed [ValueWidthDef-1:0] value;
		logic                            is_final;
		logic                            pinned;
		logic signed [ValueWidthDef-1:0] exp_value;
	} stim_row_t;

	// pinned rows are single-element runs whose result is typed in
	localparam stim_row_t DIRECTED_ROWS [23] = '{
		'{VALUE_MIN,         1'b1, 1'b1, VALUE_MIN},
		'{VALUE_MAX,         1'b1, 1'b1, VALUE_MAX},
		'{32'sd0,            1'b1, 1'b1, 32'sd0},
		'{-32'sd1,           1'b1, 1'b1, -32'sd1},
		'{32'sd5,            1'b0, 1'b0, 32'sd0},
		'{-32'sd3,           1'b0, 1'b0, 32'sd0},
		'{VALUE_MAX,         1'b0, 1'b0, 32'sd0},
		'{VALUE_MIN,         1'b0, 1'b0, 32'sd0},
		'{32'sd0,            1'b1, 1'b0, 32'sd0},
		'{32'sd7,            1'b0, 1'b0, 32'sd0},
		'{32'sd7,            1'b0, 1'b0, 32'sd0},
		'{-32'sd7,           1'b0, 1'b0, 32'sd0},
		'{32'sd7,            1'b1, 1'b0, 32'sd0},
		'{32'sd100,          1'b0, 1'b0, 32'sd0},
		'{-32'sd100,         1'b1, 1'b0, 32'sd0},
		'{-32'sd1,           1'b0, 1'b0, 32'sd0},
		'{32'sd0,            1'b0, 1'b0, 32'sd0},
		'{32'sd1,            1'b1, 1'b0, 32'sd0},
		'{32'sd1,            1'b0, 1'b0, 32'sd0},
		'{32'sd0,            1'b0, 1'b0, 32'sd0},
		'{-32'sd1,           1'b1, 1'b0, 32'sd0},
		'{32'sh5555_5555,    1'b1, 1'b1, 32'sh5555_5555},
		'{32'shaaaa_aaaa,    1'b1, 1'b1, 32'shaaaa_aaaa}
	};

	logic clk;
	logic arst_n;

	msort_in_if  #(.VALUE_WIDTH(ValueWidthDef)) din ();
	msort_out_if #(.VALUE_WIDTH(ValueWidthDef)) dout ();

	merge_sorter_core #(
		.MAX_ITEMS  (MaxItemsDef),
		.VALUE_WIDTH(ValueWidthDef)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din),
		.dout  (dout)
	);

	logic signed [ValueWidthDef-1:0] held_elements[$];
	bit                              lost_element;
	sorted_result_t                  pending_results[$];

	int mismatches;
	int results_seen;
	int elements_sent;
	int runs_sent;
	int runs_with_drops;
	int burst_left;
	int cycle_count;
	bit holdoff_done;
	logic [15:0] stall_pattern;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
		mismatches++;
	endtask

	// sorts the held run ascending and queues one result per element
	function automatic void emit_sorted_run();
		logic signed [ValueWidthDef-1:0] ordered[$];
		logic signed [ValueWidthDef-1:0] key;
		int i;
		int j;
		ordered = held_elements;
		for (i = 1; i < ordered.size(); i++) begin
			key = ordered[i];
			j = i - 1;
			while (j >= 0 && ordered[j] > key) begin
				ordered[j + 1] = ordered[j];
				j--;
			end
			ordered[j + 1] = key;
		end
		for (i = 0; i < ordered.size(); i++)
			pending_results.push_back('{ordered[i], i == ordered.size() - 1,
				i == ordered.size() - 1 && lost_element});
		if (lost_element)
			runs_with_drops++;
		held_elements.delete();
		lost_element = 1'b0;
	endfunction

	function automatic void load_element(input logic signed [ValueWidthDef-1:0] v,
		input logic fin);
		if (held_elements.size() < MaxItemsDef)
			held_elements.push_back(v);
		else
			lost_element = 1'b1;
		if (fin)
			emit_sorted_run();
	endfunction

	function automatic logic signed [ValueWidthDef-1:0] random_value();
		case ($urandom_range(0, 7))
			0, 1: return int'($urandom_range(0, 8)) - 4;
			2: begin
				case ($urandom_range(0, 3))
					0: return VALUE_MIN;
					1: return VALUE_MAX;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			3: return 32'sd1 << $urandom_range(0, ValueWidthDef - 1);
			default: return $urandom;
		endcase
	endfunction

	// one request on din, in bursts; prediction happens at the accepting edge
	task automatic send_request(input logic signed [ValueWidthDef-1:0] v, input logic fin,
		input logic pinned, input logic signed [ValueWidthDef-1:0] pinned_value);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			din.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		din.valid    <= 1'b1;
		din.value    <= v;
		din.is_final <= fin;
		do
			@(posedge clk);
		while (!din.ready);
		elements_sent++;
		if (fin)
			runs_sent++;
		if (pinned)
			pending_results.push_back('{pinned_value, 1'b1, 1'b0});
		else
			load_element(v, fin);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain_and_settle();
		din.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk) begin : check_results
		sorted_result_t want;
		if (arst_n && dout.valid && dout.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result count", results_seen, results_seen - 1);
			end else begin
				want = pending_results.pop_front();
				if (dout.sorted_value !== want.value)
					report_mismatch("sorted_value", dout.sorted_value, want.value);
				if (dout.end_of_run !== want.end_of_run)
					report_mismatch("end_of_run", dout.end_of_run, want.end_of_run);
				if (dout.dropped !== want.dropped)
					report_mismatch("dropped", dout.dropped, want.dropped);
			end
		end
	end

	// receiver: rotating stall pattern plus one long hold-off mid-drain
	initial begin
		dout.ready = 1'b0;
		stall_pattern = 16'hffff;
		forever begin
			@(negedge clk);
			if (!holdoff_done && dout.valid && results_seen >= 40) begin
				dout.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
				holdoff_done = 1'b1;
			end
			if ($urandom_range(0, 31) == 0)
				stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff
					: (16'($urandom) | 16'h1);
			dout.ready <= stall_pattern[0];
			stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
		end
	end

	initial begin
		int k;
		int run_idx;
		int run_len;
		int random_elements;
		din.valid    = 1'b0;
		din.value    = '0;
		din.is_final = 1'b0;
		arst_n       = 1'b0;
		lost_element = 1'b0;
		burst_left   = 10;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED_ROWS[i])
			send_request(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].is_final,
				DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].exp_value);

		// random runs; a full store and an overflow run are forced early
		run_idx = 0;
		random_elements = 0;
		while (random_elements < RANDOM_ELEMENTS) begin
			case (run_idx)
				2: run_len = MaxItemsDef;
				5: run_len = MaxItemsDef + 2;
				default: run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
			endcase
			for (k = 0; k < run_len; k++)
				send_request(random_value(), k == run_len - 1, 1'b0, '0);
			random_elements += run_len;
			if (run_idx == 4)
				drain_and_settle();
			run_idx++;
		end

		drain_and_settle();
		$display("sent %0d elements in %0d runs, %0d runs overflowed the store",
			elements_sent, runs_sent, runs_with_drops);
		$display("checked %0d sorted results, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
